/* design/asp_pkg.sv */
// shared types, constants and helpers for the aging priority scheduler
package asp_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int SUM_W     = IDX_W + 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [7:0]        id;
		logic signed [7:0] prio;
		logic [7:0]        need;
		logic [7:0]        runs;
	} entry_t;

	typedef enum logic {
		CMD_ADD  = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_REQUEUED = 3'd1,
		ST_FINISHED = 3'd2,
		ST_IDLE     = 3'd3,
		ST_REJECTED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_DONE
	} state_t;

	// circular slot address of logical position off behind base
	function automatic idx_t wrap_add(idx_t base, cnt_t off);
		logic [SUM_W-1:0] s;
		s = {1'b0, base} + SUM_W'(off);
		if (s >= SUM_W'(MAX_PROCS)) begin
			s = s - SUM_W'(MAX_PROCS);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic logic signed [7:0] age_prio(logic signed [7:0] p);
		return (p == -8'sd128) ? p : p - 8'sd1;
	endfunction

endpackage

/* design/aging_priority_scheduler_core.sv */
// aging priority scheduler: circular slot memory walked by one compare-and-move unit
// an add walks from the tail through the queued entries of lower priority, moving each up one slot
// a requeuing tick first takes the head off, then walks it back in with its aged priority; a finishing
// tick only takes the head off; idle and rejects go straight to the result; one slot move per cycle
// the next item is taken once the result has entered the output register
// reset clears state, head pointer, occupancy and output valid; slots stay undefined
module aging_priority_scheduler_core
	import asp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [7:0]        proc_id,
	input  logic signed [7:0] priority_req,
	input  logic [7:0]        need_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [7:0]        run_id,
	output logic signed [7:0] run_priority,
	output logic [7:0]        run_count,
	output logic [4:0]        queue_len
);

	state_t state_q, state_d;
	idx_t   head_q;
	cnt_t   occ_q;
	cnt_t   k_q;
	entry_t ins_q;

	status_t           res_status_q;
	logic [7:0]        res_id_q;
	logic signed [7:0] res_prio_q;
	logic [7:0]        res_count_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [7:0]        out_id_q;
	logic signed [7:0] out_prio_q;
	logic [7:0]        out_count_q;
	logic [4:0]        out_len_q;

	entry_t mem [MAX_PROCS];
	entry_t rd_data_q;
	logic   rd_en, wr_en;
	idx_t   rd_addr, wr_addr;
	entry_t wr_data;

	logic       accept;
	logic       is_tick;
	logic       add_ok;
	logic [7:0] head_runs;
	logic       head_done;
	logic       shift;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_tick   = (cmd_t'(cmd) == CMD_TICK);
	assign add_ok    = (need_time != 8'd0) && (occ_q != cnt_t'(MAX_PROCS));
	assign head_runs = rd_data_q.runs + 8'd1;
	assign head_done = (head_runs == rd_data_q.need);
	// the shared unit: move the entry up one slot while it ranks below the new one
	assign shift     = (k_q != '0) && ($signed(rd_data_q.prio) < $signed(ins_q.prio));
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_tick) begin
						state_d = (occ_q != '0) ? S_HEAD : S_DONE;
					end else begin
						state_d = add_ok ? S_WALK : S_DONE;
					end
				end
			end
			S_HEAD: state_d = head_done ? S_DONE : S_WALK;
			S_WALK: state_d = shift ? S_WALK : S_DONE;
			S_DONE: state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = ins_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && occ_q != '0) begin
					if (is_tick) begin
						rd_en   = 1'b1;
						rd_addr = head_q;
					end else if (add_ok) begin
						rd_en   = 1'b1;
						rd_addr = wrap_add(head_q, occ_q - cnt_t'(1));
					end
				end
			end
			S_HEAD: begin
				// tail of the queue before the head leaves
				if (!head_done && occ_q > cnt_t'(1)) begin
					rd_en   = 1'b1;
					rd_addr = wrap_add(head_q, occ_q - cnt_t'(1));
				end
			end
			S_WALK: begin
				wr_en   = 1'b1;
				wr_addr = wrap_add(head_q, k_q);
				wr_data = shift ? rd_data_q : ins_q;
				if (shift && k_q >= cnt_t'(2)) begin
					rd_en   = 1'b1;
					rd_addr = wrap_add(head_q, k_q - cnt_t'(2));
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_HEAD) begin
				head_q <= wrap_add(head_q, cnt_t'(1));
				occ_q  <= occ_q - cnt_t'(1);
			end
			if (state_q == S_WALK && !shift) begin
				occ_q <= occ_q + cnt_t'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					k_q   <= occ_q;
					ins_q <= '{id: proc_id, prio: priority_req, need: need_time, runs: 8'd0};
					if (is_tick) begin
						res_status_q <= ST_IDLE;
						res_id_q     <= 8'd0;
						res_prio_q   <= 8'sd0;
						res_count_q  <= 8'd0;
					end else begin
						res_status_q <= add_ok ? ST_ADDED : ST_REJECTED;
						res_id_q     <= proc_id;
						res_prio_q   <= priority_req;
						res_count_q  <= 8'd0;
					end
				end
			end
			S_HEAD: begin
				res_status_q <= head_done ? ST_FINISHED : ST_REQUEUED;
				res_id_q     <= rd_data_q.id;
				res_prio_q   <= rd_data_q.prio;
				res_count_q  <= head_runs;
				k_q          <= occ_q - cnt_t'(1);
				ins_q        <= '{id: rd_data_q.id, prio: age_prio(rd_data_q.prio),
				                  need: rd_data_q.need, runs: head_runs};
			end
			S_WALK: begin
				if (shift) begin
					k_q <= k_q - cnt_t'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_id_q     <= res_id_q;
					out_prio_q   <= res_prio_q;
					out_count_q  <= res_count_q;
					out_len_q    <= 5'(occ_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign run_id       = out_id_q;
	assign run_priority = out_prio_q;
	assign run_count    = out_count_q;
	assign queue_len    = out_len_q;

endmodule

/* design/asp_checker.sv */
// port-level assertions for the aging priority scheduler, bound to the top level
module asp_checker
	import asp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        status,
	input logic [7:0]        run_id,
	input logic signed [7:0] run_priority,
	input logic [7:0]        run_count,
	input logic [4:0]        queue_len
);

	// one item at a time: ready drops right after a beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(run_id)
			&& $stable(run_priority) && $stable(run_count) && $stable(queue_len))
		else $error("stalled result changed");

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_IDLE |-> run_id == 8'd0 && run_count == 8'd0
			&& queue_len == 5'd0)
		else $error("idle result with nonzero fields");

	a_dispatch_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_REQUEUED || status == ST_FINISHED)
			|-> run_count != 8'd0)
		else $error("dispatched process shows zero run count");

	a_requeue_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_REQUEUED || status == ST_ADDED)
			|-> queue_len != 5'd0 && 32'(queue_len) <= MAX_PROCS)
		else $error("queue length inconsistent with an enqueue");

endmodule

bind aging_priority_scheduler_core asp_checker u_asp_checker (.*);
